FILE: design/gdr_pkg.sv
package gdr_pkg;

  localparam int unsigned NumDirs   = 4;
  localparam int unsigned LaneWidth = 16;
  localparam int unsigned RemWidth  = 32;
  localparam int unsigned AmtWidth  = 32;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;

  localparam logic [15:0] ThresholdReset = 16'd50;

  typedef enum logic [1:0] {
    ACT_PRESS   = 2'd0,
    ACT_MOVE    = 2'd1,
    ACT_RELEASE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_STEPS   = 2'd2,
    MODE_AXIS    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    DIR_UP    = 3'd0,
    DIR_DOWN  = 3'd1,
    DIR_LEFT  = 3'd2,
    DIR_RIGHT = 3'd3,
    DIR_NONE  = 3'd4
  } dir_e;

  typedef enum logic [2:0] {
    CFG_MODES      = 3'd0,
    CFG_THRESHOLD  = 3'd1,
    CFG_STEPS      = 3'd2,
    CFG_MULTIPLIER = 3'd3,
    CFG_CODES      = 3'd4
  } cfg_idx_e;

  localparam logic KIND_AXIS    = 1'b0;
  localparam logic KIND_TRIGGER = 1'b1;

  typedef struct packed {
    logic [9:0]  modes;
    logic [15:0] threshold;
    logic [63:0] steps;
    logic [63:0] mults;
    logic [63:0] codes;
  } cfg_t;

  typedef struct packed {
    logic                kind;
    dir_e                dir;
    logic [15:0]         code;
    logic [AmtWidth-1:0] amount;
    logic                last;
  } res_t;

endpackage

FILE: design/gdr_eval.sv
module gdr_eval #(
  parameter int unsigned TOTAL_WIDTH = 32
) (
  input  logic [1:0]              action_i,
  input  logic signed [15:0]      delta_x_i,
  input  logic signed [15:0]      delta_y_i,
  input  gdr_pkg::cfg_t           cfg_i,
  input  logic [TOTAL_WIDTH-1:0]  total_x_i,
  input  logic [TOTAL_WIDTH-1:0]  total_y_i,
  input  logic [31:0]             rem_i [4],
  output logic [TOTAL_WIDTH-1:0]  total_x_o,
  output logic [TOTAL_WIDTH-1:0]  total_y_o,
  output logic [31:0]             rem_o [4],
  output gdr_pkg::res_t           res_o [2],
  output logic [1:0]              res_cnt_o
);
  import gdr_pkg::*;

  localparam logic [TOTAL_WIDTH-1:0] TotMax = {1'b0, {(TOTAL_WIDTH-1){1'b1}}};
  localparam logic [TOTAL_WIDTH-1:0] TotMin = {1'b1, {(TOTAL_WIDTH-1){1'b0}}};

  function automatic logic [TOTAL_WIDTH-1:0] sat_add(logic [TOTAL_WIDTH-1:0] t,
                                                     logic [15:0] d);
    logic [TOTAL_WIDTH:0] sum;
    sum = {t[TOTAL_WIDTH-1], t} + {{(TOTAL_WIDTH-15){d[15]}}, d};
    if (sum[TOTAL_WIDTH] != sum[TOTAL_WIDTH-1]) begin
      return sum[TOTAL_WIDTH] ? TotMin : TotMax;
    end
    return sum[TOTAL_WIDTH-1:0];
  endfunction

  function automatic logic [TOTAL_WIDTH-1:0] tot_mag(logic [TOTAL_WIDTH-1:0] t);
    return t[TOTAL_WIDTH-1] ? (~t + 1'b1) : t;
  endfunction

  function automatic logic [15:0] abs16(logic [15:0] d);
    return d[15] ? (~d + 16'd1) : d;
  endfunction

  function automatic mode_e mode_of(logic [9:0] modes, dir_e dir);
    return mode_e'(modes[{dir, 1'b0} +: 2]);
  endfunction

  logic [TOTAL_WIDTH-1:0] tx_new, ty_new, ax_new, ay_new, ax_cur, ay_cur, thr_w;
  logic [15:0]            adx, ady;
  dir_e                   dir_y, dir_x, dir_rel;
  logic                   y_act, x_act;
  logic                   y_hit, x_hit;
  res_t                   y_res, x_res, rel_res;
  logic [31:0]            y_rem, x_rem;

  // One axis of a move: axis movement or step trigger
  function automatic void act_axis(input cfg_t cfg, input dir_e dir, input logic [15:0] absd,
                                   input logic [31:0] rem, output logic hit,
                                   output res_t res, output logic [31:0] rem_n);
    logic [32:0] r33;
    logic [31:0] r32;
    logic [15:0] step;
    logic [15:0] mult;
    logic [15:0] code;
    step  = cfg.steps[{dir[1:0], 4'd0} +: 16];
    mult  = cfg.mults[{dir[1:0], 4'd0} +: 16];
    code  = cfg.codes[{dir[1:0], 4'd0} +: 16];
    r33   = {1'b0, rem} + {17'd0, absd};
    r32   = r33[32] ? 32'hFFFF_FFFF : r33[31:0];
    hit   = 1'b0;
    rem_n = rem;
    res   = '{kind: KIND_TRIGGER, dir: dir, code: 16'd0, amount: '0, last: 1'b0};
    unique case (mode_of(cfg.modes, dir))
      MODE_AXIS: begin
        hit = 1'b1;
        res = '{kind: KIND_AXIS, dir: dir, code: code,
                amount: AmtWidth'({16'd0, absd} * {16'd0, mult}), last: 1'b0};
      end
      MODE_STEPS: begin
        if (r32 >= {16'd0, step}) begin
          hit   = 1'b1;
          rem_n = r32 - {16'd0, step};
        end else begin
          rem_n = r32;
        end
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  endfunction

  always_comb begin
    tx_new = sat_add(total_x_i, delta_x_i);
    ty_new = sat_add(total_y_i, delta_y_i);
    ax_new = tot_mag(tx_new);
    ay_new = tot_mag(ty_new);
    ax_cur = tot_mag(total_x_i);
    ay_cur = tot_mag(total_y_i);
    thr_w  = {{(TOTAL_WIDTH-16){1'b0}}, cfg_i.threshold};
    adx    = abs16(delta_x_i);
    ady    = abs16(delta_y_i);
    dir_y  = delta_y_i[15] ? DIR_UP : DIR_DOWN;
    dir_x  = delta_x_i[15] ? DIR_LEFT : DIR_RIGHT;
    y_act  = (delta_y_i != 16'sd0) && (ay_new > thr_w);
    x_act  = (delta_x_i != 16'sd0) && (ax_new > thr_w);

    act_axis(cfg_i, dir_y, ady, rem_i[dir_y[1:0]], y_hit, y_res, y_rem);
    act_axis(cfg_i, dir_x, adx, rem_i[dir_x[1:0]], x_hit, x_res, x_rem);

    priority if ((ax_cur < thr_w) && (ay_cur < thr_w)) begin
      dir_rel = DIR_NONE;
    end else if (ax_cur > ay_cur) begin
      dir_rel = total_x_i[TOTAL_WIDTH-1] ? DIR_LEFT : DIR_RIGHT;
    end else begin
      dir_rel = (!total_y_i[TOTAL_WIDTH-1] && (total_y_i != '0)) ? DIR_DOWN : DIR_UP;
    end
    rel_res = '{kind: KIND_TRIGGER, dir: dir_rel, code: 16'd0, amount: '0, last: 1'b1};

    total_x_o = total_x_i;
    total_y_o = total_y_i;
    rem_o     = rem_i;
    res_o[0]  = rel_res;
    res_o[1]  = rel_res;
    res_cnt_o = 2'd0;

    unique case (action_i)
      ACT_PRESS: begin
        total_x_o = '0;
        total_y_o = '0;
        for (int i = 0; i < NumDirs; i++) begin
          rem_o[i] = '0;
        end
      end
      ACT_MOVE: begin
        total_x_o = tx_new;
        total_y_o = ty_new;
        if (y_act) begin
          rem_o[dir_y[1:0]] = y_rem;
        end
        if (x_act) begin
          rem_o[dir_x[1:0]] = x_rem;
        end
        res_o[0]      = (y_act && y_hit) ? y_res : x_res;
        res_o[1]      = x_res;
        res_cnt_o     = 2'((y_act && y_hit) ? 1 : 0) + 2'((x_act && x_hit) ? 1 : 0);
        res_o[0].last = (res_cnt_o == 2'd1);
        res_o[1].last = 1'b1;
      end
      ACT_RELEASE: begin
        total_x_o = '0;
        total_y_o = '0;
        res_cnt_o = (mode_of(cfg_i.modes, dir_rel) == MODE_RELEASE) ? 2'd1 : 2'd0;
      end
      default: begin
        res_cnt_o = 2'd0;
      end
    endcase
  end

endmodule

FILE: design/gesture_direction_recognizer_unit.sv
// Channel | Signals                                        | Direction
// input   | in_valid_i in_ready_o action_i delta_x_i delta_y_i | in
// result  | out_valid_o out_ready_i result_kind_o direction_o  | out
//         | axis_code_o axis_amount_o last_o                   |
// config  | cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i     | in
// An item is registered on accept and then evaluated into a 4-entry result queue once the
// queue has room for two results; the first result is valid after that queue write.
// One item per cycle is taken while the queue has room for two results, so throughput is set
// by the one-per-cycle result port.
// A move with two results is handed out as two separate results on the result port.
// Reset clears totals, remainders and the queue, and loads configuration reset values.
// Config writes are always ready and take effect on the next cycle.
module gesture_direction_recognizer_unit #(
  parameter int unsigned TOTAL_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [1:0]   action_i,
  input  logic [15:0]  delta_x_i,
  input  logic [15:0]  delta_y_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic         result_kind_o,
  output logic [2:0]   direction_o,
  output logic [15:0]  axis_code_o,
  output logic [31:0]  axis_amount_o,
  output logic         last_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i
);
  import gdr_pkg::*;

  cfg_t                   cfg_q;
  logic                   in_vld_q;
  logic [1:0]             action_q;
  logic [15:0]            dx_q, dy_q;
  logic [TOTAL_WIDTH-1:0] total_x_q, total_y_q, total_x_d, total_y_d;
  logic [31:0]            rem_q [4];
  logic [31:0]            rem_d [4];
  res_t                   res [2];
  logic [1:0]             res_cnt;
  res_t                   fifo_q [4];
  logic [1:0]             wptr_q, rptr_q;
  logic [2:0]             cnt_q;
  logic                   proc, in_acc, pop;
  res_t                   head;

  assign cfg_ready_o = 1'b1;
  assign proc        = in_vld_q && (cnt_q <= 3'd2);
  assign in_ready_o  = !in_vld_q || proc;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = (cnt_q != 3'd0);
  assign pop         = out_valid_o && out_ready_i;

  gdr_eval #(
    .TOTAL_WIDTH(TOTAL_WIDTH)
  ) u_eval (
    .action_i (action_q),
    .delta_x_i(dx_q),
    .delta_y_i(dy_q),
    .cfg_i    (cfg_q),
    .total_x_i(total_x_q),
    .total_y_i(total_y_q),
    .rem_i    (rem_q),
    .total_x_o(total_x_d),
    .total_y_o(total_y_d),
    .rem_o    (rem_d),
    .res_o    (res),
    .res_cnt_o(res_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q     <= '{modes: '0, threshold: ThresholdReset, steps: '0, mults: '0, codes: '0};
      in_vld_q  <= 1'b0;
      total_x_q <= '0;
      total_y_q <= '0;
      for (int i = 0; i < NumDirs; i++) begin
        rem_q[i] <= '0;
      end
      wptr_q    <= '0;
      rptr_q    <= '0;
      cnt_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_MODES:      cfg_q.modes     <= cfg_data_i[9:0];
          CFG_THRESHOLD:  cfg_q.threshold <= cfg_data_i[15:0];
          CFG_STEPS:      cfg_q.steps     <= cfg_data_i;
          CFG_MULTIPLIER: cfg_q.mults     <= cfg_data_i;
          CFG_CODES:      cfg_q.codes     <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        in_vld_q <= 1'b1;
      end else if (proc) begin
        in_vld_q <= 1'b0;
      end
      if (proc) begin
        total_x_q <= total_x_d;
        total_y_q <= total_y_d;
        rem_q     <= rem_d;
        wptr_q    <= wptr_q + res_cnt;
      end
      if (pop) begin
        rptr_q <= rptr_q + 2'd1;
      end
      cnt_q <= cnt_q + (proc ? {1'b0, res_cnt} : 3'd0) - {2'd0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      action_q <= action_i;
      dx_q     <= delta_x_i;
      dy_q     <= delta_y_i;
    end
    if (proc && (res_cnt != 2'd0)) begin
      fifo_q[wptr_q] <= res[0];
    end
    if (proc && (res_cnt == 2'd2)) begin
      fifo_q[wptr_q + 2'd1] <= res[1];
    end
  end

  assign head          = fifo_q[rptr_q];
  assign result_kind_o = head.kind;
  assign direction_o   = head.dir;
  assign axis_code_o   = head.code;
  assign axis_amount_o = head.amount;
  assign last_o        = head.last;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd4)
    else $error("result queue overflow");
  a_proc_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |-> (cnt_q <= 3'd2))
    else $error("evaluation without queue room");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_vld_q && (cnt_q > 3'd2))
    else $error("input stalled without cause");
  a_trig_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (result_kind_o == KIND_TRIGGER)) |->
      ((axis_code_o == 16'd0) && (axis_amount_o == 32'd0)))
    else $error("trigger carries axis payload");
  a_pair_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && (res_cnt == 2'd2)) |-> (!res[0].last && res[1].last))
    else $error("last flag misplaced");
`endif

endmodule

FILE: sim/gesture_direction_recognizer_unit_tb.sv
`timescale 1ns / 100ps

module gesture_direction_recognizer_unit_tb;
  import gdr_pkg::*;

  localparam int unsigned TotalW     = 32;
  localparam longint      TotMax     = (longint'(1) << (TotalW - 1)) - 1;
  localparam longint      RemMax     = 64'hFFFF_FFFF;
  localparam logic [1:0]  ActUnused  = 2'd3;
  localparam int          SettleCyc  = 6;
  localparam int          StallLimit = 1000;
  localparam int          HoldCyc    = 80;
  localparam int          PrintLimit = 40;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i      = ACT_PRESS;
  logic [15:0] delta_x_i     = '0;
  logic [15:0] delta_y_i     = '0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic        result_kind_o;
  logic [2:0]  direction_o;
  logic [15:0] axis_code_o;
  logic [31:0] axis_amount_o;
  logic        last_o;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i   = CFG_MODES;
  logic [63:0] cfg_data_i    = '0;

  gesture_direction_recognizer_unit #(.TOTAL_WIDTH(TotalW)) dut (.*);

  always #4 clk_i = ~clk_i;

  // shadow of the block's registers and gesture state
  logic [9:0]  cfg_modes  = '0;
  logic [15:0] cfg_thresh = ThresholdReset;
  logic [63:0] cfg_steps  = '0;
  logic [63:0] cfg_mults  = '0;
  logic [63:0] cfg_codes  = '0;
  longint      total_x    = 0;
  longint      total_y    = 0;
  longint      step_rem [NumDirs] = '{default: 0};
  res_t        due_results [$];

  int mismatches   = 0;
  int quiet_cycles = 0;
  int hold_req     = 0;
  int stall_left   = 0;
  bit idle_on      = 1'b1;

  function automatic longint sat_total(longint t, longint d);
    if (d > 0 && t > TotMax - d) return TotMax;
    if (d < 0 && t < -TotMax - 1 - d) return -TotMax - 1;
    return t + d;
  endfunction

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void push_result(logic kind, dir_e d, logic [15:0] code,
                                      logic [31:0] amt);
    res_t r;
    r.kind   = kind;
    r.dir    = d;
    r.code   = code;
    r.amount = amt;
    r.last   = 1'b0;
    due_results.push_back(r);
  endfunction

  function automatic void act_on_direction(dir_e d, longint travel);
    mode_e  m;
    longint acc;
    int     lane;
    lane = int'(d);
    m    = mode_e'(cfg_modes[2*lane +: 2]);
    if (m == MODE_AXIS) begin
      push_result(KIND_AXIS, d, cfg_codes[16*lane +: 16],
                  32'(travel * longint'(cfg_mults[16*lane +: 16])));
    end else if (m == MODE_STEPS) begin
      acc = step_rem[lane] + travel;
      if (acc > RemMax) acc = RemMax;
      if (acc >= longint'(cfg_steps[16*lane +: 16])) begin
        acc -= longint'(cfg_steps[16*lane +: 16]);
        push_result(KIND_TRIGGER, d, '0, '0);
      end
      step_rem[lane] = acc;
    end
  endfunction

  function automatic void apply_gesture_event(logic [1:0] act, logic [15:0] dx,
                                              logic [15:0] dy);
    longint sdx, sdy, ax, ay;
    dir_e   d;
    int     before_n;
    res_t   r;
    before_n = due_results.size();
    sdx      = longint'($signed(dx));
    sdy      = longint'($signed(dy));
    case (act)
      ACT_PRESS: begin
        total_x = 0;
        total_y = 0;
        foreach (step_rem[i]) step_rem[i] = 0;
      end
      ACT_MOVE: begin
        total_x = sat_total(total_x, sdx);
        total_y = sat_total(total_y, sdy);
        if (sdy != 0 && magnitude(total_y) > cfg_thresh)
          act_on_direction(sdy > 0 ? DIR_DOWN : DIR_UP, magnitude(sdy));
        if (sdx != 0 && magnitude(total_x) > cfg_thresh)
          act_on_direction(sdx > 0 ? DIR_RIGHT : DIR_LEFT, magnitude(sdx));
      end
      ACT_RELEASE: begin
        ax = magnitude(total_x);
        ay = magnitude(total_y);
        if (ax < cfg_thresh && ay < cfg_thresh) d = DIR_NONE;
        else if (ax > ay) d = (total_x > 0) ? DIR_RIGHT : DIR_LEFT;
        else d = (total_y > 0) ? DIR_DOWN : DIR_UP;
        total_x = 0;
        total_y = 0;
        if (mode_e'(cfg_modes[2*int'(d) +: 2]) == MODE_RELEASE)
          push_result(KIND_TRIGGER, d, '0, '0);
      end
      default: ;
    endcase
    if (due_results.size() > before_n) begin
      r      = due_results.pop_back();
      r.last = 1'b1;
      due_results.push_back(r);
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatches < PrintLimit)
      $display("%0t mismatch %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_results.size() == 0) begin
        report_mismatch("result with nothing pending", direction_o, 0);
      end else begin
        want = due_results.pop_front();
        if (result_kind_o !== want.kind)
          report_mismatch("result_kind", result_kind_o, want.kind);
        if (direction_o !== want.dir)
          report_mismatch("direction", direction_o, want.dir);
        if (axis_code_o !== want.code)
          report_mismatch("axis_code", axis_code_o, want.code);
        if (axis_amount_o !== want.amount)
          report_mismatch("axis_amount", axis_amount_o, want.amount);
        if (last_o !== want.last)
          report_mismatch("last", last_o, want.last);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("FAIL gesture_direction_recognizer_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: long hold on request, else random stall bursts
  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      out_ready_i <= 1'b0;
      hold_req--;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      stall_left = $urandom_range(0, 6);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_event(logic [1:0] act, logic [15:0] dx, logic [15:0] dy);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    delta_x_i  <= dx;
    delta_y_i  <= dy;
    do @(posedge clk_i); while (!in_ready_o);
    apply_gesture_event(act, dx, dy);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MODES:      cfg_modes  = data[9:0];
      CFG_THRESHOLD:  cfg_thresh = data[15:0];
      CFG_STEPS:      cfg_steps  = data;
      CFG_MULTIPLIER: cfg_mults  = data;
      CFG_CODES:      cfg_codes  = data;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // unused upper bits carry noise
  task automatic write_config(logic [9:0] modes, logic [15:0] thresh, logic [63:0] steps,
                              logic [63:0] mults, logic [63:0] codes);
    settle();
    write_reg(CFG_MODES, {$urandom, 22'($urandom), modes});
    write_reg(CFG_THRESHOLD, {$urandom, 16'($urandom), thresh});
    write_reg(CFG_STEPS, steps);
    write_reg(CFG_MULTIPLIER, mults);
    write_reg(CFG_CODES, codes);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [9:0] pack_modes(mode_e up, mode_e down, mode_e left,
                                            mode_e right, mode_e no_dir);
    return {no_dir, right, left, down, up};
  endfunction

  function automatic logic [63:0] pack_lanes(logic [15:0] up, logic [15:0] down,
                                             logic [15:0] left, logic [15:0] right);
    return {right, left, down, up};
  endfunction

  function automatic logic [15:0] rand_delta();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom);
      1:       return 16'h8000;
      2:       return 16'h7FFF;
      3:       return '0;
      default: return 16'(int'($urandom_range(0, 300)) - 150);
    endcase
  endfunction

  function automatic logic [15:0] rand_step();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(1, 400));
    endcase
  endfunction

  task automatic random_config();
    logic [15:0] thresh;
    case ($urandom_range(0, 5))
      0:       thresh = '0;
      1:       thresh = 16'hFFFF;
      default: thresh = 16'($urandom_range(0, 200));
    endcase
    write_config(10'($urandom), thresh,
                 pack_lanes(rand_step(), rand_step(), rand_step(), rand_step()),
                 {$urandom, $urandom}, {$urandom, $urandom});
  endtask

  // mostly press / moves / release, with some stray items
  task automatic run_gestures(int n_items);
    int sent;
    int moves;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_event(2'($urandom), 16'($urandom), 16'($urandom));
        sent++;
      end else begin
        send_event(ACT_PRESS, 16'($urandom), 16'($urandom));
        moves = $urandom_range(1, 8);
        repeat (moves) send_event(ACT_MOVE, rand_delta(), rand_delta());
        if ($urandom_range(0, 4) != 0) send_event(ACT_RELEASE, 16'($urandom), 16'($urandom));
        sent += moves + 2;
      end
    end
  endtask

  task automatic test_reset_defaults();
    send_event(ACT_PRESS, 16'h8000, 16'h7FFF);
    send_event(ACT_MOVE, 16'd100, 16'hFF9C);
    send_event(ActUnused, 16'hFFFF, 16'hFFFF);
    send_event(ACT_RELEASE, 16'h7FFF, 16'h8000);
  endtask

  task automatic test_axis_mode();
    write_config(pack_modes(MODE_AXIS, MODE_AXIS, MODE_AXIS, MODE_AXIS, MODE_RELEASE), '0, '0,
                 pack_lanes(16'd3, 16'd1, 16'd0, 16'hFFFF),
                 pack_lanes(16'hABCD, 16'h1234, 16'h0000, 16'hFFFF));
    send_event(ACT_PRESS, '0, '0);
    send_event(ACT_MOVE, 16'h8000, 16'h7FFF);
    send_event(ACT_MOVE, 16'h7FFF, 16'h8000);
    send_event(ACT_MOVE, 16'h0000, 16'h0000);
    send_event(ACT_MOVE, 16'h0001, 16'hFFFF);
    send_event(ACT_RELEASE, '0, '0);
  endtask

  // includes a zero step size and the largest one
  task automatic test_step_mode();
    write_config(pack_modes(MODE_STEPS, MODE_STEPS, MODE_STEPS, MODE_STEPS, MODE_OFF), 16'd10,
                 pack_lanes(16'd3, 16'd5, 16'd0, 16'hFFFF), '1, '1);
    send_event(ACT_PRESS, '0, '0);
    send_event(ACT_MOVE, 16'hFFFC, 16'd3);
    send_event(ACT_MOVE, 16'hFFF8, 16'd8);
    send_event(ACT_MOVE, 16'd20, 16'hFFE2);
    send_event(ACT_MOVE, 16'h7FFF, 16'd0);
    send_event(ACT_MOVE, 16'h7FFF, 16'd0);
    send_event(ACT_MOVE, 16'd1, 16'd0);
    send_event(ACT_RELEASE, '0, '0);
  endtask

  task automatic test_release_mode();
    logic [9:0] all_release;
    all_release = pack_modes(MODE_RELEASE, MODE_RELEASE, MODE_RELEASE, MODE_RELEASE,
                             MODE_RELEASE);
    write_config(all_release, 16'd50, '0, '0, '0);
    send_event(ACT_PRESS, '0, '0);
    send_event(ACT_RELEASE, '0, '0);
    send_event(ACT_MOVE, 16'd60, 16'hFFC4);
    send_event(ACT_RELEASE, '0, '0);
    send_event(ACT_MOVE, 16'hFFC3, 16'd60);
    send_event(ACT_RELEASE, '0, '0);
    send_event(ACT_MOVE, 16'd0, 16'd55);
    send_event(ACT_RELEASE, '0, '0);
    send_event(ACT_MOVE, 16'd70, 16'd0);
    send_event(ACT_RELEASE, '0, '0);
    // zero threshold, both totals zero
    write_config(all_release, '0, '0, '0, '0);
    send_event(ACT_RELEASE, '0, '0);
    write_config(pack_modes(MODE_OFF, MODE_OFF, MODE_OFF, MODE_OFF, MODE_RELEASE), 16'hFFFF,
                 '0, '0, '0);
    send_event(ACT_MOVE, 16'h7FFF, 16'h8000);
    send_event(ACT_RELEASE, '0, '0);
  endtask

  // extreme deltas pile up in the totals and a remainder
  task automatic test_large_moves();
    idle_on = 1'b0;
    write_config(pack_modes(MODE_OFF, MODE_OFF, MODE_STEPS, MODE_OFF, MODE_OFF), 16'd50,
                 '0, '0, '0);
    send_event(ACT_PRESS, '0, '0);
    repeat (16) send_event(ACT_MOVE, 16'h8000, 16'h7FFF);
    write_config(pack_modes(MODE_OFF, MODE_OFF, MODE_RELEASE, MODE_OFF, MODE_OFF), 16'd50,
                 '0, '0, '0);
    send_event(ACT_RELEASE, '0, '0);
    write_config(pack_modes(MODE_OFF, MODE_OFF, MODE_STEPS, MODE_OFF, MODE_OFF), '0,
                 pack_lanes(16'd0, 16'd0, 16'hFFFF, 16'd0), '0, '0);
    repeat (2) send_event(ACT_MOVE, 16'hFFFF, 16'h0000);
    write_config(pack_modes(MODE_OFF, MODE_OFF, MODE_OFF, MODE_OFF, MODE_OFF), 16'd50,
                 '0, '0, '0);
    send_event(ACT_PRESS, '0, '0);
    repeat (16) send_event(ACT_MOVE, 16'h7FFF, 16'h8000);
    write_config(pack_modes(MODE_RELEASE, MODE_RELEASE, MODE_RELEASE, MODE_RELEASE,
                            MODE_RELEASE), 16'd50, '0, '0, '0);
    send_event(ACT_RELEASE, '0, '0);
    idle_on = 1'b1;
  endtask

  task automatic test_random_gestures();
    for (int p = 0; p < 8; p++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      random_config();
      run_gestures(65);
    end
    idle_on = 1'b1;
  endtask

  // result side blocked while moves keep coming
  task automatic test_backpressure();
    write_config(pack_modes(MODE_AXIS, MODE_AXIS, MODE_AXIS, MODE_AXIS, MODE_AXIS), '0, '0,
                 '1, {$urandom, $urandom});
    idle_on = 1'b0;
    @(posedge clk_i);
    hold_req = HoldCyc;
    @(negedge clk_i);
    repeat (24)
      send_event(ACT_MOVE, 16'($urandom_range(1, 32767)), 16'(-int'($urandom_range(1, 32768))));
    idle_on = 1'b1;
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    random_config();
    run_gestures(80);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_axis_mode();
    test_step_mode();
    test_release_mode();
    test_large_moves();
    test_random_gestures();
    test_backpressure();
    test_full_rate();
    settle();
    repeat (20) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("PASS gesture_direction_recognizer_unit");
    end else begin
      $display("FAIL gesture_direction_recognizer_unit");
    end
    $finish;
  end

endmodule
